// File: sv/fdss_pkg.sv
// ----------------------------------------------------------------------------
// Four-digit seven-segment scanner package
// Shared types, queue defaults and the decimal segment table.
// ----------------------------------------------------------------------------
package fdss_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    cmd_t            cmd;
    digit_t [3:0]    digits;
  } entry_t;

  // Segment pattern, bit 0 = A to bit 6 = G, active high. Codes above nine are blank.
  function automatic logic [6:0] seg_pattern(input digit_t d);
    logic [6:0] seg;
    unique case (d)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h67;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: sv/fdss_front.sv
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts words, splits load values into decimal digits and pushes them.
// ----------------------------------------------------------------------------
module fdss_front
  import fdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_cmd,
  input  logic [15:0] in_value,
  output logic        push,
  output entry_t      push_entry,
  input  logic        full
);

  logic        st_valid;
  cmd_t        st_cmd;
  logic [15:0] st_value;
  logic [12:0] st_q1;
  logic [9:0]  st_q2;
  logic [6:0]  st_q3;
  logic [2:0]  st_q4;

  logic        advance;
  logic [32:0] prod1;
  logic [32:0] prod2;
  logic [32:0] prod3;
  logic [32:0] prod4;
  logic [15:0] rem0;
  logic [12:0] rem1;
  logic [9:0]  rem2;
  logic [6:0]  rem3;

  // Quotients by 10, 100, 1000 and 10000 through reciprocal multiplication.
  assign prod1 = 33'(in_value) * 33'd52429;
  assign prod2 = 33'(in_value) * 33'd83887;
  assign prod3 = 33'(in_value) * 33'd67109;
  assign prod4 = 33'(in_value) * 33'd107375;

  assign advance  = !st_valid || !full;
  assign in_ready = advance;
  assign push     = st_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (advance) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      st_cmd   <= in_cmd;
      st_value <= in_value;
      st_q1    <= prod1[31:19];
      st_q2    <= prod2[32:23];
      st_q3    <= prod3[32:26];
      st_q4    <= prod4[32:30];
    end
  end

  assign rem0 = st_value - ((16'(st_q1) << 3) + (16'(st_q1) << 1));
  assign rem1 = st_q1 - ((13'(st_q2) << 3) + (13'(st_q2) << 1));
  assign rem2 = st_q2 - ((10'(st_q3) << 3) + (10'(st_q3) << 1));
  assign rem3 = st_q3 - ((7'(st_q4) << 3) + (7'(st_q4) << 1));

  always_comb begin
    push_entry.cmd       = st_cmd;
    push_entry.digits[0] = rem0[3:0];
    push_entry.digits[1] = rem1[3:0];
    push_entry.digits[2] = rem2[3:0];
    push_entry.digits[3] = rem3[3:0];
  end

endmodule

// File: sv/fdss_queue.sv
// ----------------------------------------------------------------------------
// Scanner decoupling queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module fdss_queue
  import fdss_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

// File: sv/fdss_back.sv
// ----------------------------------------------------------------------------
// Scanner back end
// Holds the digits and scan index, and registers one segment word per tick.
// ----------------------------------------------------------------------------
module fdss_back
  import fdss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] digit_select,
  output logic [7:0] segments_n
);

  digit_t [3:0] digit_store;
  logic [1:0]   scan_index;

  assign pop = !empty && ((head.cmd == CMD_LOAD) || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_store <= '0;
      scan_index  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && (head.cmd == CMD_TICK)) begin
        out_valid  <= 1'b1;
        scan_index <= scan_index + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && (head.cmd == CMD_LOAD)) begin
        digit_store <= head.digits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.cmd == CMD_TICK)) begin
      digit_select <= scan_index;
      segments_n   <= {1'b1, ~seg_pattern(digit_store[scan_index])};
    end
  end

endmodule

// File: sv/four_digit_seven_segment_scanner_top.sv
// ----------------------------------------------------------------------------
// Four-digit seven-segment scanner
// A tick word's segment word passes through the front-end stage register, the queue and the back-end output register.
// One word is accepted per cycle through the single multiply stage in front, unless that stage is held by a full queue.
// Load words yield nothing and update the digits when they leave the queue.
// Synchronous reset clears the digits to zero and the scan index to zero.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner_top
  import fdss_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] value
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [1:0] digit_select, [9:2] segments_n, [15:10] zero
);

  logic       push;
  entry_t     push_entry;
  logic       full;
  logic       pop;
  entry_t     head;
  logic       empty;
  logic [1:0] digit_select;
  logic [7:0] segments_n;

  fdss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (cmd_t'(s_axis_tuser[0])),
    .in_value   (s_axis_tdata),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  fdss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  fdss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .digit_select (digit_select),
    .segments_n   (segments_n)
  );

  assign m_axis_tdata = {6'b0, segments_n, digit_select};

endmodule

// File: tb/four_digit_seven_segment_scanner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-digit seven-segment scanner checker
// Watches both stream channels of the scanner. Every accepted input word
// updates a private copy of the digit store or scan position. Every tick
// word queues the expected segment word. Each output word is then compared
// field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner_checker
  import fdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] value
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // [1:0] digit_select, [9:2] segments_n, [15:10] zero
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] segments_n;
    logic [1:0] digit_select;
  } scan_word_t;

  digit_t     shown_digits [4];
  logic [1:0] scan_pos;
  scan_word_t scan_words_due [$];

  function automatic logic [7:0] dark_segments_of(input digit_t d);
    logic [6:0] lit;
    case (d)
      4'd0:    lit = 7'h3F;
      4'd1:    lit = 7'h06;
      4'd2:    lit = 7'h5B;
      4'd3:    lit = 7'h4F;
      4'd4:    lit = 7'h66;
      4'd5:    lit = 7'h6D;
      4'd6:    lit = 7'h7D;
      4'd7:    lit = 7'h07;
      4'd8:    lit = 7'h7F;
      4'd9:    lit = 7'h67;
      default: lit = 7'h00;
    endcase
    return ~{1'b0, lit};
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    scan_word_t  want;
    scan_word_t  got;
    logic [15:0] rest;
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        shown_digits[k] = '0;
      end
      scan_pos = '0;
      scan_words_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (scan_words_due.size() == 0) begin
          note_mismatch("unexpected word", 16'h0, got);
        end else begin
          want = scan_words_due.pop_front();
          if (got.digit_select !== want.digit_select) begin
            note_mismatch("digit_select", 16'(want.digit_select), 16'(got.digit_select));
          end
          if (got.segments_n !== want.segments_n) begin
            note_mismatch("segments_n", 16'(want.segments_n), 16'(got.segments_n));
          end
          if (got.pad !== want.pad) begin
            note_mismatch("padding", 16'(want.pad), 16'(got.pad));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (cmd_t'(s_axis_tuser[0]) == CMD_LOAD) begin
          rest = s_axis_tdata;
          for (int k = 0; k < 4; k++) begin
            shown_digits[k] = digit_t'(rest % 16'd10);
            rest = rest / 16'd10;
          end
        end else begin
          want.pad          = '0;
          want.digit_select = scan_pos;
          want.segments_n   = dark_segments_of(shown_digits[scan_pos]);
          scan_words_due.push_back(want);
          scan_pos = scan_pos + 2'd1;
        end
      end
    end
    pending <= scan_words_due.size();
  end

endmodule

// File: tb/four_digit_seven_segment_scanner_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-digit seven-segment scanner testbench
// Sends a directed run of loads and ticks covering every digit, the value
// extremes and values above 9999, then a long random mix, with random gaps
// on the input and random stalls on the output. A separate checker predicts
// and compares the segment words.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner_top_test;
  import fdss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 1750;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  int          errors;
  int          pending;
  int          cycles;
  int          rx_wait;
  logic        calm;

  four_digit_seven_segment_scanner_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  four_digit_seven_segment_scanner_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("four_digit_seven_segment_scanner_top_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    int w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      w = calm ? 0 : $urandom_range(0, 7);
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait       <= w;
      end
    end else if (!m_axis_tready) begin
      if (rx_wait <= 1) begin
        m_axis_tready <= 1'b1;
      end
      rx_wait <= rx_wait - 1;
    end
  end

  task automatic send_word(input cmd_t cmd, input logic [15:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic tick_times(input int n);
    for (int k = 0; k < n; k++) begin
      send_word(CMD_TICK, 16'($urandom));
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] value;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    calm          = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(CMD_LOAD, 16'd0);
    tick_times(4);
    send_word(CMD_LOAD, 16'd65535);
    tick_times(4);
    send_word(CMD_LOAD, 16'd12345);
    tick_times(4);
    send_word(CMD_LOAD, 16'd6789);
    tick_times(4);
    send_word(CMD_LOAD, 16'd9999);
    tick_times(1);
    send_word(CMD_LOAD, 16'd11111);
    tick_times(2);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n % 250) >= 200;
      if (n == RANDOM_WORDS / 2) begin
        drain();
      end
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 7))
          0:       value = 16'd0;
          1:       value = 16'd9999;
          2:       value = 16'd10000;
          3:       value = 16'd65535;
          4:       value = 16'($urandom_range(0, 9999));
          default: value = 16'($urandom);
        endcase
        send_word(CMD_LOAD, value);
      end else begin
        send_word(CMD_TICK, 16'($urandom));
      end
    end
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("four_digit_seven_segment_scanner_top_test: done, clean");
    end else begin
      $display("four_digit_seven_segment_scanner_top_test: done, errors");
    end
    $finish;
  end

endmodule

// File: four_digit_seven_segment_scanner_top.f
sv/fdss_pkg.sv
sv/fdss_front.sv
sv/fdss_queue.sv
sv/fdss_back.sv
sv/four_digit_seven_segment_scanner_top.sv
tb/four_digit_seven_segment_scanner_checker.sv
tb/four_digit_seven_segment_scanner_top_test.sv
